// ----- hw/rtl/ltarb_pkg.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket arbiter package
// Item types, sequencer states, adder operations and generator constants.
// ----------------------------------------------------------------------------
package ltarb_pkg;

   localparam int unsigned DRAW_BITS = 20;
   localparam int unsigned RND_BITS  = 32;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_PICK  = 1'b1;

   localparam logic [31:0] GEN_SEED   = 32'd12345;
   localparam logic [31:0] GEN_MASK_A = 32'hFFFF_FFFE;
   localparam logic [31:0] GEN_MASK_B = 32'hFFFF_FFF8;
   localparam logic [31:0] GEN_MASK_C = 32'hFFFF_FFF0;
   localparam logic [31:0] GEN_MASK_D = 32'hFFFF_FF80;

   typedef struct packed {
      logic        kind;
      logic [3:0]  slot;
      logic [15:0] tickets;
      logic        ready_req;
      logic        present;
   } req_type;

   typedef struct packed {
      logic                 granted;
      logic [3:0]           winner;
      logic [DRAW_BITS-1:0] draw;
   } rsp_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_SUM  = 8'b0000_0010,
      ST_GEN  = 8'b0000_0100,
      ST_NEG  = 8'b0000_1000,
      ST_DIV  = 8'b0001_0000,
      ST_INC  = 8'b0010_0000,
      ST_WALK = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } state_type;

endpackage

// ----- hw/rtl/ltarb_alu.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket arbiter shared adder
// One add/subtract unit with carry out, time-shared by four sequencer steps.
// ----------------------------------------------------------------------------
module ltarb_alu
   import ltarb_pkg::*;
#(
   parameter int unsigned WIDTH = 21
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  alu_op_type       op,
   output logic [WIDTH-1:0] res,
   output logic             carry
);

   logic [WIDTH-1:0] b_eff;
   logic             cin;

   always_comb begin
      cin   = (op == ALU_SUB);
      b_eff = cin ? ~b : b;
   end

   // carry set on subtract means no borrow (a >= b)
   assign {carry, res} = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, cin};

endmodule

// ----- hw/rtl/ltarb_taus.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket arbiter random source
// Four-word combined Tausworthe generator, one step per advance pulse.
// ----------------------------------------------------------------------------
module ltarb_taus
   import ltarb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   output logic [RND_BITS-1:0] rnd
);

   logic [31:0] word_a_ff, word_a_in;
   logic [31:0] word_b_ff, word_b_in;
   logic [31:0] word_c_ff, word_c_in;
   logic [31:0] word_d_ff, word_d_in;

   always_comb begin
      word_a_in = ((word_a_ff & GEN_MASK_A) << 18) ^ (((word_a_ff << 6) ^ word_a_ff) >> 13);
      word_b_in = ((word_b_ff & GEN_MASK_B) << 2)  ^ (((word_b_ff << 2) ^ word_b_ff) >> 27);
      word_c_in = ((word_c_ff & GEN_MASK_C) << 7)  ^ (((word_c_ff << 13) ^ word_c_ff) >> 21);
      word_d_in = ((word_d_ff & GEN_MASK_D) << 13) ^ (((word_d_ff << 3) ^ word_d_ff) >> 12);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_a_ff <= GEN_SEED;
         word_b_ff <= GEN_SEED;
         word_c_ff <= GEN_SEED;
         word_d_ff <= GEN_SEED;
      end else if (advance) begin
         word_a_ff <= word_a_in;
         word_b_ff <= word_b_in;
         word_c_ff <= word_c_in;
         word_d_ff <= word_d_in;
      end
   end

   assign rnd = word_a_ff ^ word_b_ff ^ word_c_ff ^ word_d_ff;

endmodule

// ----- hw/rtl/lottery_ticket_arbiter_core.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket arbiter
// Ticket table with a sequenced pick: sum, random draw, modulo, weighted walk.
//
//   channel   ports                         dir   item
//   request   req_valid req_ready req_data  in    req_type (write or pick)
//   result    rsp_valid rsp_ready rsp_data  out   rsp_type (one per item)
//
// A pick runs a sum pass over the ticket memory, one generator step,
// 32 restoring division steps and a walk pass; the sum, the division
// and the walk all use one shared adder.
// A pick with an empty table skips the draw and the walk.
// The ticket memory has no reset; present bits gate every read of it.
// The block takes no item while busy; a result waits in the output register.
// ----------------------------------------------------------------------------
module lottery_ticket_arbiter_core
   import ltarb_pkg::*;
#(
   parameter int unsigned SLOT_COUNT  = 16,
   parameter int unsigned TICKET_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
   localparam int unsigned SUM_W = TICKET_BITS + IDX_W;
   localparam int unsigned AW    = SUM_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
   localparam logic [31:0] TICKET_MAX = (32'd1 << TICKET_BITS) - 32'd1;

   state_type state_ff, state_in;

   logic [SLOT_COUNT-1:0] present_ff, present_in;
   logic [SLOT_COUNT-1:0] ready_ff, ready_in;

   logic [TICKET_BITS-1:0] tk_mem [SLOT_COUNT];
   logic [TICKET_BITS-1:0] mem_q_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [TICKET_BITS-1:0] mem_wdata;

   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                iss_done_ff, iss_done_in;
   logic                p_vld_ff, p_vld_in;
   logic [IDX_W-1:0]    p_idx_ff, p_idx_in;
   logic                rd_en;

   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [RND_BITS-1:0] mq_ff, mq_in;
   logic [4:0]          cnt_ff, cnt_in;

   logic                 granted_ff, granted_in;
   logic [3:0]           winner_ff, winner_in;
   logic [DRAW_BITS-1:0] draw_ff, draw_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [AW-1:0]  alu_a, alu_b, alu_res;
   alu_op_type     alu_op;
   logic           alu_carry;
   logic [RND_BITS-1:0] rnd;

   logic                      req_fire;
   logic                      slot_ok;
   logic [15:0]               tk_nz;
   logic [31:0]               tk_sat;
   logic [IDX_W+3:0]          slot_wide;
   logic [IDX_W+3:0]          win_wide;
   logic [AW+DRAW_BITS-1:0]   draw_wide;
   logic                      p_elig;
   logic                      out_free;

   ltarb_alu #(.WIDTH(AW)) u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .op    (alu_op),
      .res   (alu_res),
      .carry (alu_carry)
   );

   ltarb_taus u_taus (
      .clock   (clock),
      .reset   (reset),
      .advance (state_ff == ST_GEN),
      .rnd     (rnd)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // write path: clamp ticket count, drop out-of-range slots
   always_comb begin
      slot_ok   = (32'(req_data.slot) < SLOT_COUNT);
      tk_nz     = (req_data.tickets == 16'd0) ? 16'd1 : req_data.tickets;
      tk_sat    = (32'(tk_nz) > TICKET_MAX) ? TICKET_MAX : 32'(tk_nz);
      slot_wide = {IDX_W'(0), req_data.slot};
      mem_waddr = slot_wide[IDX_W-1:0];
      mem_wdata = tk_sat[TICKET_BITS-1:0];
      mem_we    = req_fire && (req_data.kind == KIND_WRITE) && slot_ok;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tk_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= tk_mem[idx_ff];
   end

   always_comb begin
      rd_en    = ((state_ff == ST_SUM) || (state_ff == ST_WALK)) && !iss_done_ff;
      p_vld_in = rd_en;
      p_idx_in = idx_ff;
      p_elig   = p_vld_ff && present_ff[p_idx_ff] && ready_ff[p_idx_ff];
      win_wide = {4'd0, p_idx_ff};
      draw_wide = {DRAW_BITS'(0), alu_res};
   end

   // shared adder operand select
   always_comb begin
      alu_a  = '0;
      alu_b  = '0;
      alu_op = ALU_ADD;
      case (state_ff)
         ST_SUM: begin
            alu_a = AW'(acc_ff);
            alu_b = AW'(mem_q_ff);
         end
         ST_DIV: begin
            alu_a  = {rem_ff, mq_ff[RND_BITS-1]};
            alu_b  = AW'(acc_ff);
            alu_op = ALU_SUB;
         end
         ST_INC: begin
            alu_a = AW'(rem_ff);
            alu_b = AW'(1);
         end
         ST_WALK: begin
            alu_a  = AW'(rem_ff);
            alu_b  = AW'(mem_q_ff);
            alu_op = ALU_SUB;
         end
         default: begin
            alu_op = ALU_ADD;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      present_in   = present_ff;
      ready_in     = ready_ff;
      idx_in       = idx_ff;
      iss_done_in  = iss_done_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      mq_in        = mq_ff;
      cnt_in       = cnt_ff;
      granted_in   = granted_ff;
      winner_in    = winner_ff;
      draw_in      = draw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (rd_en) begin
         idx_in = idx_ff + IDX_W'(1);
         if (idx_ff == LAST_IDX) begin
            iss_done_in = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               granted_in  = 1'b0;
               winner_in   = '0;
               draw_in     = '0;
               acc_in      = '0;
               idx_in      = '0;
               iss_done_in = 1'b0;
               if (req_data.kind == KIND_WRITE) begin
                  if (slot_ok) begin
                     present_in[mem_waddr] = req_data.present;
                     ready_in[mem_waddr]   = req_data.ready_req;
                  end
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            if (p_vld_ff && present_ff[p_idx_ff]) begin
               acc_in = alu_res[SUM_W-1:0];
            end
            if (p_vld_ff && (p_idx_ff == LAST_IDX)) begin
               state_in = (acc_in == '0) ? ST_FIN : ST_GEN;
            end
         end
         ST_GEN: begin
            state_in = ST_NEG;
         end
         ST_NEG: begin
            // magnitude of the signed draw; the most negative value stays 2^31
            mq_in    = rnd[RND_BITS-1] ? (~rnd + RND_BITS'(1)) : rnd;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring division step, keep only the remainder
            rem_in = alu_carry ? alu_res[SUM_W-1:0] : alu_a[SUM_W-1:0];
            mq_in  = mq_ff << 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_INC;
            end
         end
         ST_INC: begin
            rem_in      = alu_res[SUM_W-1:0];
            draw_in     = draw_wide[DRAW_BITS-1:0];
            idx_in      = '0;
            iss_done_in = 1'b0;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            // count down the draw; the slot that reaches it wins
            if (p_elig) begin
               if (!alu_carry || (alu_res == '0)) begin
                  granted_in = 1'b1;
                  winner_in  = win_wide[3:0];
                  state_in   = ST_FIN;
               end else begin
                  rem_in = alu_res[SUM_W-1:0];
               end
            end
            if (p_vld_ff && (p_idx_ff == LAST_IDX)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in.granted = granted_ff;
               rsp_in.winner  = winner_ff;
               rsp_in.draw    = draw_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         present_ff   <= '0;
         ready_ff     <= '0;
         iss_done_ff  <= 1'b1;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         ready_ff     <= ready_in;
         iss_done_ff  <= iss_done_in;
         p_vld_ff     <= p_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      p_idx_ff   <= p_idx_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      mq_ff      <= mq_in;
      cnt_ff     <= cnt_in;
      granted_ff <= granted_in;
      winner_ff  <= winner_in;
      draw_ff    <= draw_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_div_rem_below_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < acc_ff))
      else $error("division remainder not below ticket sum");

   a_walk_draw_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (rem_ff != '0))
      else $error("walk countdown reached zero without a grant");

   a_gen_only_on_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_GEN) |=> $stable(rnd))
      else $error("generator advanced outside a pick");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && !out_free) |=> (state_ff == ST_FIN && rsp_valid_ff))
      else $error("result lost while output register busy");
`endif

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Lottery ticket arbiter testbench
// Drives write and pick items over the request channel and checks every result
// against the plan or an in-bench model of the ticket table and the Tausworthe
// draw. A short planned sequence comes first, then random traffic in three
// idling phases, with one long result stall and full drains between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import ltarb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS      = 16;
   localparam int PLAN_LEN   = 22;
   localparam int PHASE_LEN  = 660;
   localparam int STALL_LEN  = 400;

   typedef struct {
      req_type rq;
      bit      known;
      rsp_type rs;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // model of the block
   logic [15:0] lot_tickets [SLOTS];
   logic        lot_ready [SLOTS];
   logic        lot_present [SLOTS];
   logic [31:0] tw_a, tw_b, tw_c, tw_d;

   rsp_type      awaited_rsp [$];
   int           mismatch_count = 0;
   int           send_gap_pct = 0;
   int           recv_gap_pct = 0;
   int           rsp_stall_count = 0;
   plan_row_type plan [PLAN_LEN];

   lottery_ticket_arbiter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type lottery_predict(input req_type rq);
      rsp_type     res;
      logic [31:0] t, r, mag, total, g, run;
      int          i;
      res = '0;
      if (rq.kind == KIND_WRITE) begin
         lot_tickets[rq.slot] = (rq.tickets == 16'd0) ? 16'd1 : rq.tickets;
         lot_ready[rq.slot]   = rq.ready_req;
         lot_present[rq.slot] = rq.present;
      end else begin
         total = 32'd0;
         for (i = 0; i < SLOTS; i++)
            if (lot_present[i]) total += lot_tickets[i];
         // an empty table leaves the generator alone
         if (total != 32'd0) begin
            t    = ((tw_a << 6) ^ tw_a) >> 13;
            tw_a = ((tw_a & GEN_MASK_A) << 18) ^ t;
            t    = ((tw_b << 2) ^ tw_b) >> 27;
            tw_b = ((tw_b & GEN_MASK_B) << 2) ^ t;
            t    = ((tw_c << 13) ^ tw_c) >> 21;
            tw_c = ((tw_c & GEN_MASK_C) << 7) ^ t;
            t    = ((tw_d << 3) ^ tw_d) >> 12;
            tw_d = ((tw_d & GEN_MASK_D) << 13) ^ t;
            r    = tw_a ^ tw_b ^ tw_c ^ tw_d;
            // 0x80000000 negates to itself, which reads as 2^31 unsigned
            mag  = r[31] ? (~r + 32'd1) : r;
            g    = (mag % total) + 32'd1;
            res.draw = g[DRAW_BITS-1:0];
            run = 32'd0;
            for (i = 0; i < SLOTS && !res.granted; i++) begin
               if (lot_present[i] && lot_ready[i]) begin
                  if (run + lot_tickets[i] < g) begin
                     run += lot_tickets[i];
                  end else begin
                     res.granted = 1'b1;
                     res.winner  = i[3:0];
                  end
               end
            end
         end
      end
      return res;
   endfunction

   function automatic plan_row_type slot_write(input logic [3:0] s, input logic [15:0] tk,
                                               input logic rdy, input logic pres);
      plan_row_type row;
      row.rq    = '{kind: KIND_WRITE, slot: s, tickets: tk, ready_req: rdy, present: pres};
      row.known = 1'b1;
      row.rs    = '0;
      return row;
   endfunction

   function automatic plan_row_type pick_any();
      plan_row_type row;
      row.rq      = '0;
      row.rq.kind = KIND_PICK;
      row.known   = 1'b0;
      row.rs      = '0;
      return row;
   endfunction

   function automatic plan_row_type pick_known(input logic g, input logic [3:0] w,
                                               input logic [DRAW_BITS-1:0] d);
      plan_row_type row;
      row       = pick_any();
      row.known = 1'b1;
      row.rs    = '{granted: g, winner: w, draw: d};
      return row;
   endfunction

   // offer one item at the falling edge, hold it until taken
   task automatic push_item(input req_type rq, input bit known, input rsp_type known_rsp);
      rsp_type prd;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      prd = lottery_predict(rq);
      awaited_rsp.push_back(known ? known_rsp : prd);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (awaited_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic note_mismatch(input string what, input rsp_type e, input rsp_type a);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s exp granted=%0d winner=%0d draw=%0d",
                  $realtime, what, e.granted, e.winner, e.draw,
                  " got granted=%0d winner=%0d draw=%0d",
                  a.granted, a.winner, a.draw);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            note_mismatch("unexpected item", '0, rsp_data);
         end else begin
            e = awaited_rsp.pop_front();
            if (rsp_data.granted !== e.granted || rsp_data.winner !== e.winner ||
                rsp_data.draw !== e.draw)
               note_mismatch("wrong item", e, rsp_data);
         end
      end
   end

   // receiver: random back-pressure plus one long hold on request
   initial begin
      int hold_left;
      int stall_seen;
      hold_left  = 0;
      stall_seen = 0;
      forever begin
         @(negedge clock);
         if (stall_seen != rsp_stall_count) begin
            stall_seen = rsp_stall_count;
            hold_left  = STALL_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
         end
      end
   end

   initial begin
      req_type rq;
      int      ph, n, s, sel;
      int      send_pct [3];
      int      recv_pct [3];
      send_pct = '{10, 72, 0};
      recv_pct = '{72, 10, 0};
      for (s = 0; s < SLOTS; s++) begin
         lot_tickets[s] = 16'd0;
         lot_ready[s]   = 1'b0;
         lot_present[s] = 1'b0;
      end
      tw_a = GEN_SEED;
      tw_b = GEN_SEED;
      tw_c = GEN_SEED;
      tw_d = GEN_SEED;
      plan = '{
         pick_known(1'b0, 4'd0, 20'd0),           // empty table
         slot_write(4'd0, 16'd0, 1'b1, 1'b1),     // zero tickets stored as one
         pick_known(1'b1, 4'd0, 20'd1),
         slot_write(4'd15, 16'hFFFF, 1'b1, 1'b1),
         pick_any(),
         slot_write(4'd0, 16'hFFFF, 1'b0, 1'b1),
         pick_any(),
         slot_write(4'd15, 16'd100, 1'b1, 1'b0),  // remove slot, store a count of 100
         pick_any(),                              // only a non-ready slot left
         slot_write(4'd0, 16'd7, 1'b1, 1'b0),
         pick_known(1'b0, 4'd0, 20'd0),
         slot_write(4'd15, 16'd1, 1'b1, 1'b1),
         pick_known(1'b1, 4'd15, 20'd1),
         slot_write(4'd5, 16'hAAAA, 1'b1, 1'b1),
         slot_write(4'd10, 16'h5555, 1'b1, 1'b1),
         slot_write(4'd15, 16'hFFFF, 1'b0, 1'b1),
         pick_any(),
         pick_any(),
         slot_write(4'd8, 16'd3, 1'b1, 1'b1),
         pick_any(),
         slot_write(4'd5, 16'd1, 1'b0, 1'b0),
         pick_any()
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (ph = 0; ph < 3; ph++) begin
         send_gap_pct = send_pct[ph];
         recv_gap_pct = recv_pct[ph];
         if (ph == 0) begin
            for (n = 0; n < PLAN_LEN; n++)
               push_item(plan[n].rq, plan[n].known, plan[n].rs);
         end
         // starve the result side while requests keep coming
         if (ph == 2) rsp_stall_count++;
         for (n = 0; n < PHASE_LEN; n++) begin
            if ($urandom_range(149) == 0) begin
               for (s = 0; s < SLOTS; s++)
                  push_item('{kind: KIND_WRITE, slot: s[3:0], tickets: 16'($urandom),
                              ready_req: 1'($urandom), present: 1'b0}, 1'b0, '0);
            end
            rq = req_type'($urandom);
            rq.kind      = ($urandom_range(99) < 40) ? KIND_PICK : KIND_WRITE;
            rq.ready_req = ($urandom_range(99) < 75);
            rq.present   = ($urandom_range(99) < 80);
            sel = $urandom_range(7);
            case (sel)
               0: rq.tickets = 16'd0;
               1: rq.tickets = 16'hFFFF;
               2, 3: rq.tickets = 16'($urandom_range(16, 1));
               4: rq.tickets = 16'($urandom_range(1000, 1));
               default: rq.tickets = 16'($urandom);
            endcase
            push_item(rq, 1'b0, '0);
         end
         drain_results();
      end

      repeat (100) @(negedge clock);
      if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/ltarb_pkg.sv
hw/rtl/ltarb_alu.sv
hw/rtl/ltarb_taus.sv
hw/rtl/lottery_ticket_arbiter_core.sv
dv/tb_top.sv
